/* rtl/gbp_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph alpha blend package
// Shared types, register indexes and helpers that derive each color channel's
// position and depth from its configured bit mask.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int NUM_CHAN    = 3;
	localparam int CH_STAGES   = 13;
	localparam int PIPE_STAGES = CH_STAGES + 1;
	localparam int CFG_IDX_W   = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 2'd2;

	localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;

	// floor(x / 255) == (x * RECIP_255) >> 23 for every x below 65536.
	localparam logic [31:0] RECIP_255 = 32'h0000_8081;

	// Everything a channel needs to know about its field in the pixel.
	typedef struct packed {
		logic [31:0] mask;
		logic [4:0]  sh;     // trailing zeros of the mask
		logic [31:0] mx;     // 2^popcount - 1
		logic [30:0] half;   // mx / 2
		logic [24:0] kmul;   // (2^popcount - 2^(popcount mod 8)) / 255
		logic [2:0]  ksh;    // popcount mod 8
		logic        zero;   // empty mask
	} chan_cfg_t;

	function automatic logic [5:0] ones_count(input logic [31:0] m);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			n = n + 6'(m[i]);
		end
		return n;
	endfunction

	function automatic logic [4:0] trail_zeros(input logic [31:0] m);
		logic [4:0] n;
		n = '0;
		for (int i = 31; i >= 0; i--) begin
			if (m[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

	function automatic chan_cfg_t derive_cfg(input logic [31:0] m);
		chan_cfg_t  c;
		logic [5:0] b;
		logic [24:0] rep;
		b = ones_count(m);
		// 2^b is 255 * k + 2^(b mod 8), so k is a run of 0x01 bytes shifted.
		case (b[5:3])
			3'd1:    rep = 25'h000_0001;
			3'd2:    rep = 25'h000_0101;
			3'd3:    rep = 25'h001_0101;
			3'd4:    rep = 25'h101_0101;
			default: rep = 25'h000_0000;
		endcase
		c.mask = m;
		c.sh   = trail_zeros(m);
		c.mx   = 32'((33'd1 << b) - 33'd1);
		c.half = c.mx[31:1];
		c.kmul = rep << b[2:0];
		c.ksh  = b[2:0];
		c.zero = (m == 32'd0);
		return c;
	endfunction

endpackage

/* rtl/gbp_ifs.sv */
// ----------------------------------------------------------------------------
// Glyph alpha blend channels
// Request channel (coverage, text color, destination pixel) and result
// channel (new pixel, write flag), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gbp_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  coverage;
	logic [7:0]  src_red;
	logic [7:0]  src_green;
	logic [7:0]  src_blue;
	logic [31:0] dest_pixel;

	modport source (output valid, coverage, src_red, src_green, src_blue, dest_pixel,
		input ready);
	modport sink (input valid, coverage, src_red, src_green, src_blue, dest_pixel,
		output ready);
endinterface

interface gbp_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_pixel;
	logic        write_pixel;

	modport source (output valid, new_pixel, write_pixel, input ready);
	modport sink (input valid, new_pixel, write_pixel, output ready);
endinterface

/* rtl/gbp_chan.sv */
// ----------------------------------------------------------------------------
// Glyph alpha blend color channel
// Extracts one channel from the destination pixel, blends it with the text
// color and converts the result back into the pixel's field, over 13 stages.
// ----------------------------------------------------------------------------
module gbp_chan (
	input  logic                          clk,
	input  logic [gbp_pkg::CH_STAGES:1]  en,
	input  gbp_pkg::chan_cfg_t            cfg,
	input  logic [31:0]                   dst,
	input  logic [7:0]                    src,
	input  logic [7:0]                    cov,
	output logic [31:0]                   field
);
	import gbp_pkg::*;

	// Restoring divide step: quotient bit on top, remainder below.
	function automatic logic [41:0] div_step(input logic [40:0] rem, input logic [40:0] dsh);
		logic [41:0] res;
		if (rem >= dsh) begin
			res = {1'b1, rem - dsh};
		end else begin
			res = {1'b0, rem};
		end
		return res;
	endfunction

	logic [31:0] v_s1;
	logic [7:0]  src_s1, cov_s1;
	logic [40:0] n_s2;
	logic [7:0]  src_s2, cov_s2;
	logic [40:0] r_s3, r_s4, r_s5;
	logic [7:0]  q_s3, q_s4, q_s5;
	logic        sat_s3, sat_s4, sat_s5;
	logic [7:0]  src_s3, cov_s3, src_s4, cov_s4, src_s5, cov_s5;
	logic [7:0]  d_s6, src_s6, cov_s6;
	logic [15:0] pa_s7, pb_s7;
	logic [15:0] x_s8;
	logic [7:0]  c_s9;
	logic [31:0] ck_s10;
	logic [15:0] in_s10;
	logic [31:0] ck_s11;
	logic [7:0]  iq_s11;
	logic [31:0] cv_s12;
	logic [31:0] field_s13;

	logic [40:0] dv;
	logic [41:0] st7, st6, st5, st4, st3, st2, st1, st0;
	logic [31:0] xm, im;

	always_comb begin
		dv  = 41'(cfg.mx);
		st7 = div_step(n_s2, dv << 7);
		st6 = div_step(st7[40:0], dv << 6);
		st5 = div_step(r_s3, dv << 5);
		st4 = div_step(st5[40:0], dv << 4);
		st3 = div_step(r_s4, dv << 3);
		st2 = div_step(st3[40:0], dv << 2);
		st1 = div_step(r_s5, dv << 1);
		st0 = div_step(st1[40:0], dv);
		xm  = 32'(x_s8) * RECIP_255;
		im  = 32'(in_s10) * RECIP_255;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			v_s1   <= (dst & cfg.mask) >> cfg.sh;
			src_s1 <= src;
			cov_s1 <= cov;
		end
		if (en[2]) begin
			n_s2   <= 41'({v_s1, 8'h00}) - 41'(v_s1) + 41'(cfg.half);
			src_s2 <= src_s1;
			cov_s2 <= cov_s1;
		end
		if (en[3]) begin
			// A quotient of 256 or more saturates at full scale.
			sat_s3 <= (n_s2 >= (dv << 8));
			r_s3   <= st6[40:0];
			q_s3   <= {st7[41], st6[41], 6'd0};
			src_s3 <= src_s2;
			cov_s3 <= cov_s2;
		end
		if (en[4]) begin
			sat_s4 <= sat_s3;
			r_s4   <= st4[40:0];
			q_s4   <= q_s3 | {2'd0, st5[41], st4[41], 4'd0};
			src_s4 <= src_s3;
			cov_s4 <= cov_s3;
		end
		if (en[5]) begin
			sat_s5 <= sat_s4;
			r_s5   <= st2[40:0];
			q_s5   <= q_s4 | {4'd0, st3[41], st2[41], 2'd0};
			src_s5 <= src_s4;
			cov_s5 <= cov_s4;
		end
		if (en[6]) begin
			if (cfg.zero) begin
				d_s6 <= 8'd0;
			end else if (sat_s5) begin
				d_s6 <= 8'hFF;
			end else begin
				d_s6 <= q_s5 | {6'd0, st1[41], st0[41]};
			end
			src_s6 <= src_s5;
			cov_s6 <= cov_s5;
		end
		if (en[7]) begin
			pa_s7 <= 16'(src_s6) * 16'(cov_s6);
			pb_s7 <= 16'(d_s6) * 16'(8'hFF - cov_s6);
		end
		if (en[8]) begin
			x_s8 <= pa_s7 + pb_s7;
		end
		if (en[9]) begin
			c_s9 <= xm[30:23];
		end
		if (en[10]) begin
			ck_s10 <= 32'(cfg.kmul) * 32'(c_s9);
			in_s10 <= (16'(c_s9) << cfg.ksh) - 16'(c_s9) + 16'd127;
		end
		if (en[11]) begin
			ck_s11 <= ck_s10;
			iq_s11 <= im[30:23];
		end
		if (en[12]) begin
			cv_s12 <= ck_s11 + 32'(iq_s11);
		end
		if (en[13]) begin
			field_s13 <= (cv_s12 << cfg.sh) & cfg.mask;
		end
	end

	assign field = field_s13;

endmodule

/* rtl/glyph_alpha_blend_pixel.sv */
// ----------------------------------------------------------------------------
// Glyph alpha blend pixel
// Blends an 8-bit text color into a truecolor destination pixel by glyph
// coverage, with red, green and blue field masks set through a write port.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the 14-stage pipeline is the only limit,
//   and a stall at the result side holds the occupied stages while empty ones fill.
// Reset: arst_n clears all stage valid bits and loads the default masks
//   (red 0x00FF0000, green 0x0000FF00, blue 0x000000FF).
module glyph_alpha_blend_pixel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
	input  logic [31:0]                     cfg_wr_data,
	gbp_req_if.sink                         req,
	gbp_rsp_if.source                       rsp
);
	import gbp_pkg::*;

	// Per-channel configuration. The derived shift, depth and reciprocal terms
	// are computed from the write data as it arrives, so a request that comes
	// right after a write already sees consistent values.
	chan_cfg_t cfg_q [NUM_CHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= derive_cfg(RED_MASK_RST);
			cfg_q[1] <= derive_cfg(GREEN_MASK_RST);
			cfg_q[2] <= derive_cfg(BLUE_MASK_RST);
		end else if (cfg_wr_en) begin
			case (cfg_wr_idx)
				REG_RED_MASK:   cfg_q[0] <= derive_cfg(cfg_wr_data);
				REG_GREEN_MASK: cfg_q[1] <= derive_cfg(cfg_wr_data);
				REG_BLUE_MASK:  cfg_q[2] <= derive_cfg(cfg_wr_data);
				default: ;
			endcase
		end
	end

	// Pipeline flow control. Each stage loads when it is empty or when the
	// stage after it moves on; the last stage moves on when the result is
	// taken. The request side is ready exactly when stage one can load.
	logic [PIPE_STAGES:1] vld_s;
	logic [PIPE_STAGES:1] stage_en;

	always_comb begin
		stage_en[PIPE_STAGES] = !vld_s[PIPE_STAGES] || rsp.ready;
		for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
			stage_en[k] = !vld_s[k] || stage_en[k + 1];
		end
	end

	assign req.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (stage_en[1]) begin
				vld_s[1] <= req.valid;
			end
			for (int k = 2; k <= PIPE_STAGES; k++) begin
				if (stage_en[k]) begin
					vld_s[k] <= vld_s[k - 1];
				end
			end
		end
	end

	// Zero coverage bypasses the blend: the destination pixel and the flag
	// ride alongside the channel pipelines and pick the result at the end.
	// Full coverage needs no special path, since the blend then returns the
	// text color exactly.
	logic [31:0]        dst_s  [1:CH_STAGES];
	logic [CH_STAGES:1] zero_s;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			dst_s[1]  <= req.dest_pixel;
			zero_s[1] <= (req.coverage == 8'd0);
		end
		for (int k = 2; k <= CH_STAGES; k++) begin
			if (stage_en[k]) begin
				dst_s[k]  <= dst_s[k - 1];
				zero_s[k] <= zero_s[k - 1];
			end
		end
	end

	// One channel pipeline per color. Each returns its converted value
	// already shifted into place and masked to its field.
	logic [7:0]  src_arr [NUM_CHAN];
	logic [31:0] fld     [NUM_CHAN];

	always_comb begin
		src_arr[0] = req.src_red;
		src_arr[1] = req.src_green;
		src_arr[2] = req.src_blue;
	end

	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		gbp_chan u_chan (
			.clk   (clk),
			.en    (stage_en[CH_STAGES:1]),
			.cfg   (cfg_q[c]),
			.dst   (req.dest_pixel),
			.src   (src_arr[c]),
			.cov   (req.coverage),
			.field (fld[c])
		);
	end

	// Result register: the fields are merged, or the untouched destination
	// pixel goes out with the write flag low.
	logic [31:0] pix_or;
	logic [31:0] new_pixel_s14;
	logic        write_pixel_s14;

	always_comb begin
		pix_or = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			pix_or = pix_or | fld[c];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[PIPE_STAGES]) begin
			new_pixel_s14   <= zero_s[CH_STAGES] ? dst_s[CH_STAGES] : pix_or;
			write_pixel_s14 <= !zero_s[CH_STAGES];
		end
	end

	assign rsp.valid       = vld_s[PIPE_STAGES];
	assign rsp.new_pixel   = new_pixel_s14;
	assign rsp.write_pixel = write_pixel_s14;

	// The request side only stalls when every stage holds a request and the
	// result is not being taken.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> ((&vld_s) && !rsp.ready))
		else $error("request side stalled with room in the pipeline");

	// A request accepted with no result leaving adds exactly one occupied stage.
	a_occupancy_up: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !(rsp.valid && rsp.ready)) |=>
		($countones(vld_s) == $past($countones(vld_s)) + 1))
		else $error("pipeline occupancy did not grow by one on an accepted request");

	// A result taken with no new request removes exactly one occupied stage.
	a_occupancy_down: assert property (@(posedge clk) disable iff (!arst_n)
		(!(req.valid && req.ready) && rsp.valid && rsp.ready) |=>
		($countones(vld_s) == $past($countones(vld_s)) - 1))
		else $error("pipeline occupancy did not shrink by one on a taken result");

endmodule
